/* rtl/core/stkc_pkg.sv */
`timescale 1ns / 1ps

package stkc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int DEPTH_W     = 5;
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_POP  = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;

endpackage

/* rtl/core/stkc_alu.sv */
`timescale 1ns / 1ps

module stkc_alu
(
    input  logic [2:0]                 op,
    input  logic [stkc_pkg::DATA_W-1:0] a,
    input  logic [stkc_pkg::DATA_W-1:0] b,
    output logic [stkc_pkg::DATA_W-1:0] y
);

    always_comb
    begin
        case (op)
            stkc_pkg::CMD_ADD: y = a + b;
            stkc_pkg::CMD_SUB: y = a - b;
            stkc_pkg::CMD_MUL: y = a * b;
            default:           y = '0;
        endcase
    end

endmodule

/* rtl/core/stack_calculator.sv */
// Accept to done strobe: push passes S_PUSH; pop S_POP_A, S_FIN; add, subtract and
// multiply S_POP_A, S_POP_B, S_LOADB, S_EXEC, S_PUSH; unknown commands S_FIN. busy
// drops as the strobe shows; a new command may start only then. The stack RAM's single
// registered read port and the shared ALU set these steps. The receiver cannot stall.
// Reset (rst_n, async, active low) empties the stack and sets capacity to 16.
`timescale 1ns / 1ps

module stack_calculator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          command,
    input  logic signed [stkc_pkg::DATA_W-1:0]  push_value,
    output logic                                done,
    output logic signed [stkc_pkg::DATA_W-1:0]  result_value,
    output logic [stkc_pkg::DEPTH_W-1:0]        stack_depth,
    output logic                                overflow,
    output logic                                underflow,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_POP_A = 7'b0000010,
        S_POP_B = 7'b0000100,
        S_LOADB = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_PUSH  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    localparam int DW = stkc_pkg::DATA_W;

    state_t                          state_reg, state_next;
    logic [stkc_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [stkc_pkg::CAP_W-1:0]      cap_reg;
    logic [2:0]                      cmd_reg, cmd_next;
    logic [DW-1:0]                   a_reg, a_next;
    logic [DW-1:0]                   b_reg, b_next;
    logic [DW-1:0]                   res_reg, res_next;
    logic                            miss_reg, miss_next;
    logic                            under_reg, under_next;
    logic                            done_reg, done_next;
    logic [DW-1:0]                   out_val_reg, out_val_next;
    logic [stkc_pkg::DEPTH_W-1:0]    out_depth_reg, out_depth_next;
    logic                            out_over_reg, out_over_next;
    logic                            out_under_reg, out_under_next;

    logic [DW-1:0]                   mem [stkc_pkg::STACK_DEPTH];
    logic [DW-1:0]                   rd_data_reg;
    logic [stkc_pkg::CNT_W-1:0]      count_dec;
    logic [stkc_pkg::ADDR_W-1:0]     rd_addr;
    logic [stkc_pkg::ADDR_W-1:0]     wr_addr;
    logic                            mem_we;

    logic [stkc_pkg::LIM_W-1:0]      cap_ext;
    logic [stkc_pkg::LIM_W-1:0]      depth_max;
    logic [stkc_pkg::LIM_W-1:0]      limit;
    logic                            full;
    logic [DW-1:0]                   alu_y;
    logic                            cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == stkc_pkg::REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= stkc_pkg::CAP_RESET;
        end
        else if (cfg_wr && (paddr[2] == stkc_pkg::REG_CAPACITY))
        begin
            cap_reg <= pwdata[stkc_pkg::CAP_W-1:0];
        end
    end

    assign cap_ext   = stkc_pkg::LIM_W'(cap_reg);
    assign depth_max = stkc_pkg::LIM_W'(stkc_pkg::STACK_DEPTH);
    assign limit     = (cap_ext > depth_max) ? depth_max : cap_ext;
    assign full      = stkc_pkg::LIM_W'(count_reg) >= limit;

    // stack RAM
    assign count_dec = count_reg - 1'b1;
    assign rd_addr   = count_dec[stkc_pkg::ADDR_W-1:0];
    assign wr_addr   = count_reg[stkc_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= res_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    stkc_alu u_alu
    (
        .op (cmd_reg),
        .a  (a_reg),
        .b  (b_reg),
        .y  (alu_y)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        miss_next      = miss_reg;
        under_next     = under_reg;
        done_next      = 1'b0;
        out_val_next   = out_val_reg;
        out_depth_next = out_depth_reg;
        out_over_next  = out_over_reg;
        out_under_next = out_under_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    res_next   = push_value;
                    under_next = 1'b0;
                    unique case (command) inside
                        stkc_pkg::CMD_PUSH: state_next = S_PUSH;
                        stkc_pkg::CMD_ADD,
                        stkc_pkg::CMD_SUB,
                        stkc_pkg::CMD_MUL,
                        stkc_pkg::CMD_POP:  state_next = S_POP_A;
                        default:            state_next = S_FIN;
                    endcase
                end
            end
            S_POP_A:
            begin
                if (count_reg == '0)
                begin
                    miss_next  = 1'b1;
                    under_next = 1'b1;
                end
                else
                begin
                    miss_next  = 1'b0;
                    count_next = count_dec;
                end
                state_next = (cmd_reg == stkc_pkg::CMD_POP) ? S_FIN : S_POP_B;
            end
            S_POP_B:
            begin
                a_next = miss_reg ? '0 : rd_data_reg;
                if (count_reg == '0)
                begin
                    miss_next  = 1'b1;
                    under_next = 1'b1;
                end
                else
                begin
                    miss_next  = 1'b0;
                    count_next = count_dec;
                end
                state_next = S_LOADB;
            end
            S_LOADB:
            begin
                b_next     = miss_reg ? '0 : rd_data_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_next   = alu_y;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!full)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                done_next      = 1'b1;
                out_val_next   = res_reg;
                out_depth_next = stkc_pkg::DEPTH_W'(count_next);
                out_over_next  = full;
                out_under_next = under_reg;
                state_next     = S_IDLE;
            end
            S_FIN:
            begin
                done_next      = 1'b1;
                out_val_next   = ((cmd_reg == stkc_pkg::CMD_POP) && !miss_reg) ? rd_data_reg : '0;
                out_depth_next = stkc_pkg::DEPTH_W'(count_reg);
                out_over_next  = 1'b0;
                out_under_next = under_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            under_reg <= 1'b0;
            miss_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            under_reg <= under_next;
            miss_reg  <= miss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_reg       <= res_next;
        out_val_reg   <= out_val_next;
        out_depth_reg <= out_depth_next;
        out_over_reg  <= out_over_next;
        out_under_reg <= out_under_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = out_val_reg;
    assign stack_depth  = out_depth_reg;
    assign overflow     = out_over_reg;
    assign underflow    = out_under_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stkc_pkg::CNT_W'(stkc_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance count");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held longer than one cycle");

endmodule

/* bench/stack_calculator_checker.sv */
`timescale 1ns / 1ps

module stack_calculator_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [2:0]                          command,
    input  logic [stkc_pkg::DATA_W-1:0]         push_value,
    input  logic                                done,
    input  logic [stkc_pkg::DATA_W-1:0]         result_value,
    input  logic [stkc_pkg::DEPTH_W-1:0]        stack_depth,
    input  logic                                overflow,
    input  logic                                underflow,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    output int                                  errors,
    output int                                  pending,
    output int                                  overflows_seen,
    output int                                  underflows_seen
);

    typedef struct packed {
        logic [stkc_pkg::DATA_W-1:0]  value;
        logic [stkc_pkg::DEPTH_W-1:0] depth;
        logic                         ovf;
        logic                         unf;
    } calc_word_t;

    calc_word_t                   expected_words[$];
    logic [stkc_pkg::DATA_W-1:0]  stack_mem [stkc_pkg::STACK_DEPTH];
    logic [stkc_pkg::DEPTH_W-1:0] held;
    logic [stkc_pkg::CAP_W-1:0]   cap_reg;
    int                           fail_count;
    int                           ovf_count;
    int                           unf_count;

    task automatic pop_entry(output logic [stkc_pkg::DATA_W-1:0] v, inout logic unf);
        if (held == 0)
        begin
            unf = 1'b1;
            v = '0;
        end
        else
        begin
            held = held - 1'b1;
            v = stack_mem[held[stkc_pkg::ADDR_W-1:0]];
        end
    endtask

    task automatic push_entry(input logic [stkc_pkg::DATA_W-1:0] v, inout logic ovf);
        int limit;
        limit = (cap_reg < stkc_pkg::STACK_DEPTH) ? int'(cap_reg)
                                                  : stkc_pkg::STACK_DEPTH;
        if (int'(held) >= limit)
            ovf = 1'b1;
        else
        begin
            stack_mem[held[stkc_pkg::ADDR_W-1:0]] = v;
            held = held + 1'b1;
        end
    endtask

    task automatic predict_word(input logic [2:0] cmd,
                                input logic [stkc_pkg::DATA_W-1:0] val);
        calc_word_t                  w;
        logic [stkc_pkg::DATA_W-1:0] a;
        logic [stkc_pkg::DATA_W-1:0] b;
        logic [stkc_pkg::DATA_W-1:0] res;
        logic                        ovf;
        logic                        unf;
        ovf = 1'b0;
        unf = 1'b0;
        res = '0;
        case (cmd) inside
            stkc_pkg::CMD_PUSH:
            begin
                res = val;
                push_entry(val, ovf);
            end
            stkc_pkg::CMD_ADD, stkc_pkg::CMD_SUB, stkc_pkg::CMD_MUL:
            begin
                // first pop is the top entry
                pop_entry(a, unf);
                pop_entry(b, unf);
                if (cmd == stkc_pkg::CMD_ADD)
                    res = a + b;
                else if (cmd == stkc_pkg::CMD_SUB)
                    res = a - b;
                else
                    res = a * b;
                push_entry(res, ovf);
            end
            stkc_pkg::CMD_POP:
                pop_entry(res, unf);
            default: ;
        endcase
        w.value = res;
        w.depth = held;
        w.ovf = ovf;
        w.unf = unf;
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        calc_word_t w;
        if (!rst_n)
        begin
            expected_words.delete();
            held = '0;
            cap_reg = stkc_pkg::CAP_RESET;
            fail_count = 0;
            ovf_count = 0;
            unf_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no command pending: value %h depth %0d",
                           result_value, stack_depth);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (result_value !== w.value)
                    begin
                        $error("result_value: expected %h, got %h", w.value, result_value);
                        fail_count++;
                    end
                    if (stack_depth !== w.depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d", w.depth, stack_depth);
                        fail_count++;
                    end
                    if (overflow !== w.ovf)
                    begin
                        $error("overflow: expected %b, got %b", w.ovf, overflow);
                        fail_count++;
                    end
                    if (underflow !== w.unf)
                    begin
                        $error("underflow: expected %b, got %b", w.unf, underflow);
                        fail_count++;
                    end
                    if (w.ovf)
                        ovf_count++;
                    if (w.unf)
                        unf_count++;
                end
            end
            if (start && !busy)
                predict_word(command, push_value);
            if (psel && penable && pwrite && pready
                && paddr[2] == stkc_pkg::REG_CAPACITY)
                cap_reg = pwdata[stkc_pkg::CAP_W-1:0];
        end
        errors <= fail_count;
        pending <= expected_words.size();
        overflows_seen <= ovf_count;
        underflows_seen <= unf_count;
    end

endmodule

/* bench/stack_calculator_tb.sv */
`timescale 1ns / 1ps

module stack_calculator_tb;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic [2:0]                     command = stkc_pkg::CMD_PUSH;
    logic [stkc_pkg::DATA_W-1:0]    push_value = '0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;

    logic                           busy;
    logic                           done;
    logic [stkc_pkg::DATA_W-1:0]    result_value;
    logic [stkc_pkg::DEPTH_W-1:0]   stack_depth;
    logic                           overflow;
    logic                           underflow;
    logic [31:0]                    prdata;
    logic                           pready;

    int                             errors;
    int                             pending;
    int                             overflows_seen;
    int                             underflows_seen;
    int                             n_words = 0;
    int                             n_caps = 0;
    int                             idle_pct = 0;
    int                             push_w = 50;

    stack_calculator DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .push_value(push_value),
        .done(done),
        .result_value(result_value),
        .stack_depth(stack_depth),
        .overflow(overflow),
        .underflow(underflow),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    stack_calculator_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .push_value(push_value),
        .done(done),
        .result_value(result_value),
        .stack_depth(stack_depth),
        .overflow(overflow),
        .underflow(underflow),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .errors(errors),
        .pending(pending),
        .overflows_seen(overflows_seen),
        .underflows_seen(underflows_seen)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic issue_word(input logic [2:0] c, input logic [stkc_pkg::DATA_W-1:0] v);
        start <= 1'b1;
        command <= c;
        push_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_words++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // drain outstanding words before touching the register
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == stkc_pkg::REG_CAPACITY)
            n_caps++;
    endtask

    function automatic logic [stkc_pkg::DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command();
        int s;
        if ($urandom_range(99) < push_w)
            return stkc_pkg::CMD_PUSH;
        s = $urandom_range(19);
        if (s == 0)
            return 3'($urandom_range(5, 7));
        if (s < 6)
            return stkc_pkg::CMD_POP;
        case ($urandom_range(2))
            0: return stkc_pkg::CMD_ADD;
            1: return stkc_pkg::CMD_SUB;
            default: return stkc_pkg::CMD_MUL;
        endcase
    endfunction

    initial
    begin
        logic [stkc_pkg::CAP_W-1:0] cap_pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty stack, wraparound, operand order, unknown commands
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_ADD, '0);
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_PUSH, 32'h7fff_ffff);
        issue_word(stkc_pkg::CMD_PUSH, 32'd1);
        issue_word(stkc_pkg::CMD_ADD, '1);
        issue_word(stkc_pkg::CMD_PUSH, 32'h8000_0000);
        issue_word(stkc_pkg::CMD_PUSH, '1);
        issue_word(stkc_pkg::CMD_MUL, '0);
        issue_word(stkc_pkg::CMD_SUB, '0);
        issue_word(stkc_pkg::CMD_PUSH, 32'd5);
        issue_word(stkc_pkg::CMD_PUSH, 32'd3);
        issue_word(stkc_pkg::CMD_SUB, '0);
        issue_word(3'd5, 32'hdead_beef);
        issue_word(3'd7, '0);
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_POP, '0);

        // unmapped address must leave capacity alone
        settle();
        apb_write(3'd4, 32'd1);
        issue_word(stkc_pkg::CMD_PUSH, 32'd21);
        issue_word(stkc_pkg::CMD_PUSH, 32'd22);

        // capacity below depth: held entries stay, pushes drop
        settle();
        apb_write({stkc_pkg::REG_CAPACITY, 2'b00}, 32'd1);
        issue_word(stkc_pkg::CMD_PUSH, 32'd11);
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_PUSH, 32'd12);
        issue_word(stkc_pkg::CMD_PUSH, 32'd13);

        settle();
        apb_write({stkc_pkg::REG_CAPACITY, 2'b00}, 32'd0);
        issue_word(stkc_pkg::CMD_PUSH, 32'd14);
        issue_word(stkc_pkg::CMD_POP, '0);
        issue_word(stkc_pkg::CMD_ADD, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int seg = 0; seg < 5; seg++)
            begin
                case (seg)
                    0: cap_pick = 5'd31;
                    1: cap_pick = stkc_pkg::CAP_RESET;
                    2: cap_pick = 5'd1;
                    default: cap_pick = stkc_pkg::CAP_W'($urandom_range(0, 31));
                endcase
                settle();
                idle_pct = (phase == 0) ? 12 : (phase == 1) ? 50 : 0;
                apb_write({stkc_pkg::REG_CAPACITY, 2'b00},
                          {$urandom} & ~32'h1f | 32'(cap_pick));
                push_w = $urandom_range(30, 75);
                for (int k = 0; k < 50; k++)
                    issue_word(pick_command(), pick_operand());
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d command words over %0d capacity writes, including 0, 1, 16 and 31.",
                 n_words, n_caps);
        $display("Checked %0d overflow and %0d underflow results.",
                 overflows_seen, underflows_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/core/stkc_pkg.sv
rtl/core/stkc_alu.sv
rtl/core/stack_calculator.sv
bench/stack_calculator_checker.sv
bench/stack_calculator_tb.sv
